// ----- rtl/core/kcd_pkg.sv -----
// Shared constants, codes and control/status types of the keyboard command dispatcher.
// No dependencies; used by kcd_ctrl, kcd_dp and keyboard_command_dispatcher.
package kcd_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int LINE_DEPTH    = 32;
	localparam int TIDX_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int LIDX_W        = $clog2(LINE_DEPTH);

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_USER_W = 2;

	localparam logic [7:0] CH_NUL  = 8'd0;
	localparam logic [7:0] CH_LF   = 8'd10;
	localparam logic [7:0] CH_CR   = 8'd13;
	localparam logic [7:0] CH_OPEN = 8'd37;

	localparam logic REQ_KEY = 1'b0;
	localparam logic REQ_REG = 1'b1;

	localparam logic KIND_ECHO = 1'b0;
	localparam logic KIND_CMD  = 1'b1;

	typedef enum logic [1:0] {
		ES_LINE,
		ES_TERM,
		ES_ECHO,
		ES_LF
	} emit_sel_t;

	typedef struct packed {
		logic      load_item;
		logic      key_from_ch;
		logic      key_from_line;
		logic      scan_clr;
		logic      scan_adv;
		logic      tab_write;
		logic      open_line;
		logic      close_line;
		logic      store_char;
		logic      rd_rst;
		logic      rd_adv;
		logic      emit;
		emit_sel_t emit_sel;
	} ctl_t;

	typedef struct packed {
		logic req_type;
		logic ch_is_open;
		logic ch_is_cr;
		logic ch_is_lf;
		logic ch_is_nul;
		logic line_open;
		logic line_full;
		logic scan_last;
		logic found;
		logic rd_more;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/core/kcd_ctrl.sv -----
// Sequencing state machine of the keyboard command dispatcher.
// Depends on kcd_pkg; drives kcd_dp through ctl_t and reads its sts_t.
module kcd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  kcd_pkg::sts_t sts,
	output kcd_pkg::ctl_t ctl
);
	import kcd_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DEC    = 4'd1;
	localparam logic [3:0] S_KEYRD  = 4'd2;
	localparam logic [3:0] S_KEYGET = 4'd3;
	localparam logic [3:0] S_SCAN_A = 4'd4;
	localparam logic [3:0] S_SCAN_C = 4'd5;
	localparam logic [3:0] S_SEND   = 4'd6;
	localparam logic [3:0] S_LRD    = 4'd7;
	localparam logic [3:0] S_LEMIT  = 4'd8;
	localparam logic [3:0] S_TERM   = 4'd9;
	localparam logic [3:0] S_ECHO   = 4'd10;
	localparam logic [3:0] S_LF     = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		ctl      = '0;
		ctl.emit_sel = ES_ECHO;
		state_d  = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load_item = 1'b1;
					state_d       = S_DEC;
				end
			end
			S_DEC: begin
				priority if (sts.req_type == REQ_REG) begin
					ctl.key_from_ch = 1'b1;
					ctl.scan_clr    = 1'b1;
					state_d         = S_SCAN_A;
				end else if (!sts.line_open && sts.ch_is_open) begin
					ctl.open_line = 1'b1;
					state_d       = S_ECHO;
				end else if (sts.line_open && (sts.ch_is_cr || sts.ch_is_lf)) begin
					ctl.close_line = 1'b1;
					ctl.rd_rst     = 1'b1;
					state_d        = S_KEYRD;
				end else if (sts.line_open && !sts.line_full) begin
					ctl.store_char = 1'b1;
					state_d        = S_ECHO;
				end else begin
					state_d = S_ECHO;
				end
			end
			S_KEYRD: state_d = S_KEYGET;
			S_KEYGET: begin
				ctl.key_from_line = 1'b1;
				ctl.scan_clr      = 1'b1;
				state_d           = S_SCAN_A;
			end
			S_SCAN_A: state_d = S_SCAN_C;
			S_SCAN_C: begin
				ctl.scan_adv = 1'b1;
				state_d      = sts.scan_last ? S_SEND : S_SCAN_A;
			end
			S_SEND: begin
				priority if (sts.req_type == REQ_REG) begin
					ctl.tab_write = 1'b1;
					state_d       = S_IDLE;
				end else if (sts.found) begin
					ctl.rd_rst = 1'b1;
					state_d    = S_LRD;
				end else begin
					state_d = S_ECHO;
				end
			end
			S_LRD: state_d = S_LEMIT;
			S_LEMIT: begin
				priority if (!sts.rd_more) begin
					state_d = S_TERM;
				end else if (sts.out_free) begin
					ctl.emit     = 1'b1;
					ctl.emit_sel = ES_LINE;
					ctl.rd_adv   = 1'b1;
					state_d      = S_LRD;
				end
			end
			S_TERM: begin
				if (sts.out_free) begin
					ctl.emit     = 1'b1;
					ctl.emit_sel = ES_TERM;
					state_d      = S_ECHO;
				end
			end
			S_ECHO: begin
				priority if (sts.ch_is_nul) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					ctl.emit     = 1'b1;
					ctl.emit_sel = ES_ECHO;
					state_d      = sts.ch_is_cr ? S_LF : S_IDLE;
				end
			end
			S_LF: begin
				if (sts.out_free) begin
					ctl.emit     = 1'b1;
					ctl.emit_sel = ES_LF;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/core/kcd_dp.sv -----
// Datapath of the keyboard command dispatcher: item register, command table,
// line buffer, table scan and output register. Depends on kcd_pkg.
module kcd_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  kcd_pkg::ctl_t            ctl,
	output kcd_pkg::sts_t            sts,
	input  logic                     in_req_type,
	input  logic [7:0]               in_char,
	input  logic [3:0]               in_sender,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic                     out_kind,
	output logic [3:0]               out_id,
	output logic [7:0]               out_char,
	output logic                     out_eom,
	output logic                     out_last
);
	import kcd_pkg::*;

	logic                     req_q;
	logic [7:0]               ch_q;
	logic [3:0]               sid_q;
	logic [7:0]               key_q;

	logic [11:0]              tab_mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] tab_valid_q;
	logic [11:0]              tab_rd_q;
	logic [TIDX_W-1:0]        sc_q;
	logic                     found_q;
	logic [TIDX_W-1:0]        found_idx_q;
	logic [3:0]               dest_q;
	logic                     free_q;
	logic [TIDX_W-1:0]        free_idx_q;
	logic [TIDX_W-1:0]        slot;

	logic [7:0]               line_mem [LINE_DEPTH];
	logic                     line_open_q;
	logic [LIDX_W-1:0]        len_q;
	logic [LIDX_W-1:0]        rd_idx_q;
	logic [7:0]               rd_data_q;

	logic                     out_valid_q;
	logic                     kind_q;
	logic [3:0]               id_q;
	logic [7:0]               och_q;
	logic                     eom_q;
	logic                     last_q;

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			req_q <= in_req_type;
			ch_q  <= in_char;
			sid_q <= in_sender;
		end
		if (ctl.key_from_ch) begin
			key_q <= ch_q;
		end else if (ctl.key_from_line) begin
			key_q <= (len_q != '0) ? rd_data_q : CH_NUL;
		end
	end

	assign slot = found_q ? found_idx_q : free_idx_q;

	always_ff @(posedge clk) begin
		tab_rd_q <= tab_mem[sc_q];
		if (ctl.tab_write && (found_q || free_q)) begin
			tab_mem[slot] <= {sid_q, ch_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_valid_q <= '0;
			sc_q        <= '0;
			found_q     <= 1'b0;
			free_q      <= 1'b0;
		end else begin
			if (ctl.tab_write && (found_q || free_q)) begin
				tab_valid_q[slot] <= 1'b1;
			end
			if (ctl.scan_clr) begin
				sc_q    <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end else if (ctl.scan_adv) begin
				sc_q <= sc_q + 1'b1;
				if (tab_valid_q[sc_q] && (tab_rd_q[7:0] == key_q) && !found_q) begin
					found_q <= 1'b1;
				end
				if (!tab_valid_q[sc_q] && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.scan_adv) begin
			if (tab_valid_q[sc_q] && (tab_rd_q[7:0] == key_q) && !found_q) begin
				found_idx_q <= sc_q;
				dest_q      <= tab_rd_q[11:8];
			end
			if (!tab_valid_q[sc_q] && !free_q) begin
				free_idx_q <= sc_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= line_mem[rd_idx_q];
		if (ctl.store_char) begin
			line_mem[len_q] <= ch_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_open_q <= 1'b0;
			len_q       <= '0;
			rd_idx_q    <= '0;
		end else begin
			if (ctl.open_line) begin
				line_open_q <= 1'b1;
				len_q       <= '0;
			end else if (ctl.close_line) begin
				line_open_q <= 1'b0;
			end else if (ctl.store_char) begin
				len_q <= len_q + 1'b1;
			end
			if (ctl.rd_rst) begin
				rd_idx_q <= '0;
			end else if (ctl.rd_adv) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			unique case (ctl.emit_sel)
				ES_LINE: begin
					kind_q <= KIND_CMD;
					id_q   <= dest_q;
					och_q  <= rd_data_q;
					eom_q  <= 1'b0;
					last_q <= 1'b0;
				end
				ES_TERM: begin
					kind_q <= KIND_CMD;
					id_q   <= dest_q;
					och_q  <= CH_NUL;
					eom_q  <= 1'b1;
					last_q <= (ch_q == CH_NUL);
				end
				ES_ECHO: begin
					kind_q <= KIND_ECHO;
					id_q   <= 4'd0;
					och_q  <= ch_q;
					eom_q  <= (ch_q != CH_CR);
					last_q <= (ch_q != CH_CR);
				end
				ES_LF: begin
					kind_q <= KIND_ECHO;
					id_q   <= 4'd0;
					och_q  <= CH_LF;
					eom_q  <= 1'b1;
					last_q <= 1'b1;
				end
				default: begin
					kind_q <= KIND_ECHO;
					id_q   <= 4'd0;
					och_q  <= CH_NUL;
					eom_q  <= 1'b1;
					last_q <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_id    = id_q;
	assign out_char  = och_q;
	assign out_eom   = eom_q;
	assign out_last  = last_q;

	always_comb begin
		sts.req_type   = req_q;
		sts.ch_is_open = (ch_q == CH_OPEN);
		sts.ch_is_cr   = (ch_q == CH_CR);
		sts.ch_is_lf   = (ch_q == CH_LF);
		sts.ch_is_nul  = (ch_q == CH_NUL);
		sts.line_open  = line_open_q;
		sts.line_full  = (len_q == LIDX_W'(LINE_DEPTH - 1));
		sts.scan_last  = (sc_q == TIDX_W'(TABLE_ENTRIES - 1));
		sts.found      = found_q;
		sts.rd_more    = (rd_idx_q < len_q) && (rd_data_q != CH_NUL);
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule

// ----- rtl/core/keyboard_command_dispatcher.sv -----
// Top level of the keyboard command dispatcher: stream ports and packing.
// Depends on kcd_pkg, kcd_ctrl and kcd_dp.
//
// Usage: items enter on the s_axis channel; tuser marks a keystroke (0) or a
// key registration (1). Results leave on the m_axis channel, one character a
// beat, tlast on the final result an item causes. A keystroke other than NUL
// gives its echo (CR as CR then LF); a CR or LF that closes a line bound to a
// registered key first streams the buffered text and a zero terminator to
// that destination. Registrations give no result.
// One item is handled at a time; s_axis_tready is high only while idle.
// A plain keystroke passes through the decode and echo states; its echo is
// held in the output register. A registration, and the lookup of a closing
// keystroke, scan every table entry in turn, one entry per S_SCAN_A/S_SCAN_C
// pass through the registered table memory; a bound key then streams its
// characters through S_LRD and S_LEMIT, paced by the registered line buffer
// read port.
// A single output register holds each result; when m_axis_tready is low the
// sequencer holds until it frees, and the next item can be taken while the
// last result still waits. Reset empties the table and closes any line.
module keyboard_command_dispatcher (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [7:0] char_code, [11:8] sender_id, [15:12] zero
	input  logic [kcd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// [0] req_type
	input  logic [0:0]                     s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [3:0] dest_id, [11:4] char_code_res, [15:12] zero
	output logic [kcd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// [0] dest_kind, [1] end_of_message
	output logic [kcd_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output logic                           m_axis_tlast
);
	import kcd_pkg::*;

	ctl_t       ctl;
	sts_t       sts;
	logic       kind;
	logic [3:0] id;
	logic [7:0] och;
	logic       eom;

	kcd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	kcd_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.in_req_type (s_axis_tuser[0]),
		.in_char     (s_axis_tdata[7:0]),
		.in_sender   (s_axis_tdata[11:8]),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_kind    (kind),
		.out_id      (id),
		.out_char    (och),
		.out_eom     (eom),
		.out_last    (m_axis_tlast)
	);

	assign m_axis_tdata = {4'd0, och, id};
	assign m_axis_tuser = {eom, kind};

endmodule
